// ----- src/sbs_pkg.sv -----
package sbs_pkg;

  // Geometry limits: frame sizes above these are clamped.
  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  // The row counter sticks here, on a row that is never used.
  localparam int unsigned RowStick   = 8191;
  // Depth of the queue between classification and result generation.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_SKIP_LINES   = 3'd2,
    REG_HALVE_WIDTH  = 3'd3,
    REG_DOUBLE_ROWS  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [10:0] skip_lines;
    logic        halve_width;
    logic        double_rows;
  } cfg_t;

  // One classified request: everything the back end needs to write results.
  typedef struct packed {
    logic [7:0]  value;
    logic [10:0] row;
    logic [12:0] col;
    logic [1:0]  plane;
    logic        dbl;
  } op_t;

endpackage

// ----- src/stereo_top_bottom_to_side_by_side_core.sv -----
// Path: an accepted sample's request is written into the queue, then loaded into the result
// register, which drives the result port. Throughput: one sample per cycle while samples give
// one result on average and results are popped; when copying with row doubling each sample
// gives two results and the result port moves one per cycle, so the full queue holds input back.
// Reset (rst_ni, asynchronous, active low) restores the register defaults 640, 480, 0, 1, 0,
// clears the counters, held sample and plane, and empties the queue and result register.
module stereo_top_bottom_to_side_by_side_core import sbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample input, queue style.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sample_i,
  input  logic [1:0]  plane_i,
  input  logic        first_i,
  // Result output, queue style.
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  value_o,
  output logic [11:0] out_row_o,
  output logic [12:0] out_col_o,
  output logic [1:0]  out_plane_o,
  output logic        last_o,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  // The configuration is always ready; the user must make writes only while the block is idle,
  // as the block does not enforce this, so the geometry is read straight from these registers.
  cfg_t cfg_q;
  logic op_valid, q_full, q_empty, q_rd;
  op_t  op, q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= 13'd640;
      cfg_q.frame_height <= 13'd480;
      cfg_q.skip_lines   <= 11'd0;
      cfg_q.halve_width  <= 1'b1;
      cfg_q.double_rows  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        REG_SKIP_LINES:   cfg_q.skip_lines   <= cfg_data_i[10:0];
        REG_HALVE_WIDTH:  cfg_q.halve_width  <= cfg_data_i[0];
        REG_DOUBLE_ROWS:  cfg_q.double_rows  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The front end tracks the raster position of each sample and decides in the same
  // cycle whether it yields a result, and where; only those become requests.
  assign full = q_full;

  sbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .sample_i   (sample_i),
    .plane_i    (plane_i),
    .first_i    (first_i),
    .q_full_i   (q_full),
    .op_valid_o (op_valid),
    .op_o       (op)
  );

  // A short queue decouples acceptance of samples from delivery of results.
  sbs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (op_valid),
    .wr_data_i (op),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  // The back end turns each request into one result, or two when rows are doubled, through a
  // result register; under a stall the queue holds requests, and once it is full input is held.
  sbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .value_o     (value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_plane_o (out_plane_o),
    .last_o      (last_o)
  );

endmodule

// ----- src/sbs_front.sv -----
module sbs_front import sbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       push_i,
  input  logic [7:0] sample_i,
  input  logic [1:0] plane_i,
  input  logic       first_i,
  input  logic       q_full_i,
  output logic       op_valid_o,
  output op_t        op_o
);

  logic [11:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [7:0]  held_q, held_d;
  logic [1:0]  plane_q, plane_d;

  logic        accept;
  logic [11:0] c;
  logic [12:0] r;
  logic [1:0]  pl;
  logic [12:0] w, h, pw, pw_eff, rstart, rend, c_next, rdiff;
  logic [11:0] dd, half, cnt;
  logic [10:0] sk;
  logic        cnt_pos, in_left, in_right, col_ok, emit;
  logic [8:0]  sum;

  assign accept = push_i && !q_full_i;

  always_comb begin
    c  = first_i ? '0 : col_q;
    r  = first_i ? '0 : row_q;
    pl = first_i ? plane_i : plane_q;

    w = (cfg_i.frame_width  > 13'(MaxWidth))  ? 13'(MaxWidth)  : cfg_i.frame_width;
    h = (cfg_i.frame_height > 13'(MaxHeight)) ? 13'(MaxHeight) : cfg_i.frame_height;

    if (pl == 2'd0) begin
      pw   = w;
      dd   = w[12:1];
      half = h[12:1];
      sk   = cfg_i.skip_lines;
    end else begin
      pw   = {1'b0, w[12:1]};
      dd   = {1'b0, w[12:2]};
      half = {1'b0, h[12:2]};
      sk   = {1'b0, cfg_i.skip_lines[10:1]};
    end
    pw_eff = (pw == '0) ? 13'd1 : pw;

    // Used rows: the left view starts at row zero, the right view after the seam.
    cnt_pos  = half > {1'b0, sk};
    cnt      = half - {1'b0, sk};
    rstart   = {1'b0, half} + {2'b00, sk};
    rend     = {half, 1'b0};
    in_left  = cnt_pos && (r < {1'b0, cnt});
    in_right = cnt_pos && !in_left && (r >= rstart) && (r < rend);
    rdiff    = r - rstart;
    col_ok   = {1'b0, c} < {dd, 1'b0};
    sum      = {1'b0, held_q} + {1'b0, sample_i};

    op_o.plane = pl;
    op_o.dbl   = cfg_i.double_rows;
    op_o.row   = in_right ? rdiff[10:0] : r[10:0];
    if (cfg_i.halve_width) begin
      emit       = c[0];
      op_o.value = sum[8:1];
      op_o.col   = {2'b00, c[11:1]} + (in_right ? {1'b0, dd} : 13'd0);
    end else begin
      emit       = 1'b1;
      op_o.value = sample_i;
      op_o.col   = {1'b0, c} + (in_right ? {dd, 1'b0} : 13'd0);
    end
    op_valid_o = accept && (in_left || in_right) && col_ok && emit;

    // Counter update, taken only when a sample is accepted.
    c_next  = {1'b0, c} + 13'd1;
    col_d   = col_q;
    row_d   = row_q;
    held_d  = held_q;
    plane_d = plane_q;
    if (accept) begin
      plane_d = pl;
      if (!c[0]) begin
        held_d = sample_i;
      end
      if (c_next >= pw_eff) begin
        col_d = '0;
        row_d = (r < 13'(RowStick)) ? r + 13'd1 : r;
      end else begin
        col_d = c_next[11:0];
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      held_q  <= '0;
      plane_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      held_q  <= held_d;
      plane_q <= plane_d;
    end
  end

endmodule

// ----- src/sbs_queue.sv -----
module sbs_queue import sbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  wr_data_i,
  input  logic rd_i,
  output op_t  rd_data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CntW'(QueueDepth));
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QueueDepth))
    else $error("queue occupancy beyond its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("request written into a full queue");
`endif

endmodule

// ----- src/sbs_back.sv -----
module sbs_back import sbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  op_t         q_data_i,
  output logic        q_rd_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  value_o,
  output logic [11:0] out_row_o,
  output logic [12:0] out_col_o,
  output logic [1:0]  out_plane_o,
  output logic        last_o
);

  logic        out_v_q, out_v_d;
  logic        phase_q, phase_d;
  logic [7:0]  value_q;
  logic [11:0] row_q, row_d;
  logic [12:0] col_q;
  logic [1:0]  plane_q;
  logic        last_q, last_d;
  logic        load;

  assign load = !q_empty_i && (!out_v_q || pop_i);

  always_comb begin
    phase_d = phase_q;
    q_rd_o  = 1'b0;
    row_d   = row_q;
    last_d  = last_q;
    if (load) begin
      if (q_data_i.dbl && !phase_q) begin
        // First of a doubled pair: the request stays at the head.
        row_d   = {q_data_i.row, 1'b0};
        last_d  = 1'b0;
        phase_d = 1'b1;
      end else begin
        row_d   = q_data_i.dbl ? {q_data_i.row, 1'b1} : {1'b0, q_data_i.row};
        last_d  = 1'b1;
        phase_d = 1'b0;
        q_rd_o  = 1'b1;
      end
    end
    out_v_d = load || (out_v_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= q_data_i.value;
      col_q   <= q_data_i.col;
      plane_q <= q_data_i.plane;
    end
    row_q  <= row_d;
    last_q <= last_d;
  end

  assign empty_o     = !out_v_q;
  assign value_o     = value_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign out_plane_o = plane_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q |-> !q_empty_i)
    else $error("second row of a pair pending with no request queued");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (out_v_q && !last_q) |-> phase_q)
    else $error("non-final result shown without its pair pending");
`endif

endmodule
